>>> rtl/core/rmq_pkg.sv
package rmq_pkg;

    // Element width and fixed-point format (Q1.FRAC).
    localparam int DATA_WIDTH = 16;
    localparam int FRAC       = DATA_WIDTH - 2;
    // Width of the trace and of the root argument before clamping.
    localparam int SUM_W      = DATA_WIDTH + 2;
    // Width of a sum or difference of two elements.
    localparam int DIFF_W     = DATA_WIDTH + 1;
    // Width of the square-root and divider remainders.
    localparam int REM_W      = 2 * DATA_WIDTH + 1;
    // Register stages in one divider.
    localparam int DIV_LAT    = DATA_WIDTH + 3;

    // Which quaternion component the square root produces directly.
    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    // Control and operands that travel beside the square root.
    typedef struct packed {
        logic                     valid;
        t_branch                  own;
        logic signed [DIFF_W-1:0] d0;
        logic signed [DIFF_W-1:0] d1;
        logic signed [DIFF_W-1:0] d2;
    } t_side;

    // Control that travels beside the dividers.
    typedef struct packed {
        logic                  valid;
        t_branch               own;
        logic [DATA_WIDTH-1:0] own_val;
        logic                  deg;
    } t_tag;

    // One finished result.
    typedef struct packed {
        logic                         deg;
        logic signed [DATA_WIDTH-1:0] w;
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
    } t_result;

endpackage

>>> rtl/core/rmq_pre.sv
module rmq_pre (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m00,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m01,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m02,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m10,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m11,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m12,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m20,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m21,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m22,
    output logic        [rmq_pkg::DATA_WIDTH-1:0]  o_arg,
    output rmq_pkg::t_side                         o_side
);
    import rmq_pkg::*;

    localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) << FRAC;

    logic signed [SUM_W-1:0]  e00, e11, e22;
    logic signed [SUM_W-1:0]  trace;
    logic signed [SUM_W-1:0]  arg_raw;
    logic [DATA_WIDTH-1:0]    n_arg;
    t_side                    n_side;
    logic [DATA_WIDTH-1:0]    r_arg;
    t_side                    r_side;

    // The diagonal is widened so the trace and the root argument are exact.
    assign e00   = SUM_W'(i_m00);
    assign e11   = SUM_W'(i_m11);
    assign e22   = SUM_W'(i_m22);
    assign trace = e00 + e11 + e22;

    // Branch choice, root argument and the three off-diagonal terms.
    always_comb begin
        n_side.valid = i_valid;
        if (trace > 0) begin
            n_side.own = BR_TRACE;
            arg_raw    = trace + ONE_S;
            n_side.d0  = DIFF_W'(i_m21) - DIFF_W'(i_m12);
            n_side.d1  = DIFF_W'(i_m02) - DIFF_W'(i_m20);
            n_side.d2  = DIFF_W'(i_m10) - DIFF_W'(i_m01);
        end else if ((e00 > e11) && (e00 > e22)) begin
            n_side.own = BR_X;
            arg_raw    = ONE_S + e00 - e11 - e22;
            n_side.d0  = DIFF_W'(i_m21) - DIFF_W'(i_m12);
            n_side.d1  = DIFF_W'(i_m01) + DIFF_W'(i_m10);
            n_side.d2  = DIFF_W'(i_m02) + DIFF_W'(i_m20);
        end else if (e11 > e22) begin
            n_side.own = BR_Y;
            arg_raw    = ONE_S + e11 - e00 - e22;
            n_side.d0  = DIFF_W'(i_m02) - DIFF_W'(i_m20);
            n_side.d1  = DIFF_W'(i_m01) + DIFF_W'(i_m10);
            n_side.d2  = DIFF_W'(i_m12) + DIFF_W'(i_m21);
        end else begin
            n_side.own = BR_Z;
            arg_raw    = ONE_S + e22 - e00 - e11;
            n_side.d0  = DIFF_W'(i_m10) - DIFF_W'(i_m01);
            n_side.d1  = DIFF_W'(i_m02) + DIFF_W'(i_m20);
            n_side.d2  = DIFF_W'(i_m12) + DIFF_W'(i_m21);
        end
    end

    // Clamp the argument to the range zero to just under four.
    always_comb begin
        if (arg_raw[SUM_W-1]) begin
            n_arg = '0;
        end else if (|arg_raw[SUM_W-2:DATA_WIDTH]) begin
            n_arg = '1;
        end else begin
            n_arg = arg_raw[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arg <= n_arg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= n_side;
        end
    end

    assign o_arg  = r_arg;
    assign o_side = r_side;

endmodule

>>> rtl/core/rmq_sqrt.sv
module rmq_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [rmq_pkg::DATA_WIDTH-1:0]    i_arg,
    input  rmq_pkg::t_side                    i_side,
    output logic [rmq_pkg::DATA_WIDTH-1:0]    o_root,
    output rmq_pkg::t_side                    o_side
);
    import rmq_pkg::*;

    // One result bit per stage, most significant first.
    logic [REM_W-1:0]      r_rem  [DATA_WIDTH-1];
    logic [DATA_WIDTH-1:0] r_root [DATA_WIDTH];
    t_side                 r_side [DATA_WIDTH];

    for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_stage
        localparam int BIT = DATA_WIDTH - 1 - j;

        logic [REM_W-1:0]      rem_in;
        logic [DATA_WIDTH-1:0] root_in;
        t_side                 side_in;
        logic [REM_W-1:0]      trial;
        logic                  fits;

        if (j == 0) begin : g_first
            // The argument is scaled by 2^(FRAC+2) so the root is 2*sqrt(arg).
            assign rem_in  = REM_W'(i_arg) << (FRAC + 2);
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign side_in = r_side[j-1];
        end

        // Setting this bit adds root*2^(BIT+1) + 2^(2*BIT) to the square.
        assign trial = (REM_W'(root_in) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
        assign fits  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= fits ? (root_in | (DATA_WIDTH'(1) << BIT)) : root_in;
            end
        end

        if (j < DATA_WIDTH - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= fits ? (rem_in - trial) : rem_in;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j].valid <= 1'b0;
            end else if (i_en) begin
                r_side[j] <= side_in;
            end
        end
    end

    assign o_root = r_root[DATA_WIDTH-1];
    assign o_side = r_side[DATA_WIDTH-1];

endmodule

>>> rtl/core/rmq_div.sv
module rmq_div (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [rmq_pkg::DIFF_W-1:0]     i_d,
    input  logic        [rmq_pkg::DATA_WIDTH-1:0] i_s,
    output logic signed [rmq_pkg::DATA_WIDTH-1:0] o_quo
);
    import rmq_pkg::*;

    localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  n_neg;
    logic [DIFF_W-1:0]     mag;
    logic [REM_W-1:0]      n_num;

    logic [REM_W-1:0]      r_num0;
    logic [DIFF_W-1:0]     r_den0;
    logic                  r_neg0;

    logic [REM_W-1:0]      r_rem1;
    logic [DIFF_W-1:0]     r_den1;
    logic                  r_neg1;
    logic                  r_ovf1;

    logic [REM_W-1:0]      r_rem  [DATA_WIDTH-1];
    logic [DIFF_W-1:0]     r_den  [DATA_WIDTH-1];
    logic [DATA_WIDTH-1:0] r_quo  [DATA_WIDTH];
    logic                  r_neg  [DATA_WIDTH];
    logic                  r_ovf  [DATA_WIDTH];

    logic [DATA_WIDTH-1:0] q_fin;
    logic [DATA_WIDTH-1:0] n_out;
    logic [DATA_WIDTH-1:0] r_out;

    // Numerator 2*|d|*2^FRAC + s over denominator 2*s rounds half away from zero.
    assign n_neg = i_d[DIFF_W-1];
    assign mag   = n_neg ? DIFF_W'(-i_d) : DIFF_W'(i_d);
    assign n_num = (REM_W'(mag) << (FRAC + 1)) + REM_W'(i_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num0 <= n_num;
            r_den0 <= {i_s, 1'b0};
            r_neg0 <= n_neg;
        end
    end

    // A quotient of 2^DATA_WIDTH or more saturates in any case.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem1 <= r_num0;
            r_den1 <= r_den0;
            r_neg1 <= r_neg0;
            r_ovf1 <= (r_num0 >= (REM_W'(r_den0) << DATA_WIDTH));
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_stage
        localparam int BIT = DATA_WIDTH - 1 - j;

        logic [REM_W-1:0]      rem_in;
        logic [DIFF_W-1:0]     den_in;
        logic [DATA_WIDTH-1:0] quo_in;
        logic                  neg_in;
        logic                  ovf_in;
        logic [REM_W-1:0]      sub;
        logic                  fits;

        if (j == 0) begin : g_first
            assign rem_in = r_rem1;
            assign den_in = r_den1;
            assign quo_in = '0;
            assign neg_in = r_neg1;
            assign ovf_in = r_ovf1;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign neg_in = r_neg[j-1];
            assign ovf_in = r_ovf[j-1];
        end

        assign sub  = REM_W'(den_in) << BIT;
        assign fits = (rem_in >= sub);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= fits ? (quo_in | (DATA_WIDTH'(1) << BIT)) : quo_in;
                r_neg[j] <= neg_in;
                r_ovf[j] <= ovf_in;
            end
        end

        if (j < DATA_WIDTH - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= fits ? (rem_in - sub) : rem_in;
                    r_den[j] <= den_in;
                end
            end
        end
    end

    // Apply the sign and saturate to the signed range.
    assign q_fin = r_quo[DATA_WIDTH-1];

    always_comb begin
        if (r_ovf[DATA_WIDTH-1] || q_fin[DATA_WIDTH-1]) begin
            n_out = r_neg[DATA_WIDTH-1] ? SMIN : SMAX;
        end else if (r_neg[DATA_WIDTH-1]) begin
            n_out = ~q_fin + DATA_WIDTH'(1);
        end else begin
            n_out = q_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_quo = r_out;

endmodule

>>> rtl/core/rotation_matrix_to_quaternion_core.sv
// Converts a 3x3 rotation matrix in signed Q1.14 to the unit quaternion
// (w, x, y, z) in Q1.14 by the four-branch trace method: the trace branch when
// the trace is above zero, otherwise the branch of the largest diagonal element
// (ties go to the later element). The block accepts one matrix every clock
// cycle while o_stall is low. The pipeline is the input register, the
// bit-per-stage square root (DATA_WIDTH stages), the bit-per-stage dividers
// (DATA_WIDTH + 3 stages) and the output register. A two-entry output buffer
// lets one more request in while a result is held by the downstream stall.
// When the square root comes out zero, all four components are zero and
// o_degenerate is set.
module rotation_matrix_to_quaternion_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m00,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m01,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m02,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m10,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m11,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m12,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m20,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m21,
    input  logic signed [rmq_pkg::DATA_WIDTH-1:0]  i_m22,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [rmq_pkg::DATA_WIDTH-1:0]  o_quat_w,
    output logic signed [rmq_pkg::DATA_WIDTH-1:0]  o_quat_x,
    output logic signed [rmq_pkg::DATA_WIDTH-1:0]  o_quat_y,
    output logic signed [rmq_pkg::DATA_WIDTH-1:0]  o_quat_z,
    output logic                                   o_degenerate
);
    import rmq_pkg::*;

    logic                     pipe_en;
    logic [DATA_WIDTH-1:0]    pre_arg;
    t_side                    pre_side;
    logic [DATA_WIDTH-1:0]    sq_root;
    t_side                    sq_side;
    t_tag                     n_tag;
    t_tag                     r_tag [DIV_LAT];
    logic signed [DATA_WIDTH-1:0] quo0, quo1, quo2;
    t_tag                     fin_tag;
    t_result                  fin;
    logic                     out_take;

    t_result                  r_out;
    logic                     r_out_valid;
    t_result                  r_skid;
    logic                     r_skid_valid;

    // The whole pipeline moves unless the skid entry is occupied.
    assign pipe_en = !r_skid_valid;
    assign o_stall = r_skid_valid;

    rmq_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .o_arg   (pre_arg),
        .o_side  (pre_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_arg   (pre_arg),
        .i_side  (pre_side),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    rmq_div u_div0 (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_d   (sq_side.d0),
        .i_s   (sq_root),
        .o_quo (quo0)
    );

    rmq_div u_div1 (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_d   (sq_side.d1),
        .i_s   (sq_root),
        .o_quo (quo1)
    );

    rmq_div u_div2 (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_d   (sq_side.d2),
        .i_s   (sq_root),
        .o_quo (quo2)
    );

    // The branch's own component is s/4 rounded half up.
    always_comb begin
        n_tag.valid   = sq_side.valid;
        n_tag.own     = sq_side.own;
        n_tag.own_val = DATA_WIDTH'((DIFF_W'(sq_root) + DIFF_W'(2)) >> 2);
        n_tag.deg     = (sq_root == '0);
    end

    // Control delay line matching the divider latency.
    for (genvar k = 0; k < DIV_LAT; k++) begin : g_tag
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k].valid <= 1'b0;
            end else if (pipe_en) begin
                r_tag[k] <= (k == 0) ? n_tag : r_tag[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign fin_tag = r_tag[DIV_LAT-1];

    // Place the own component and the three quotients.
    always_comb begin
        fin.deg = fin_tag.deg;
        if (fin_tag.deg) begin
            fin.w = '0;
            fin.x = '0;
            fin.y = '0;
            fin.z = '0;
        end else begin
            case (fin_tag.own)
                BR_TRACE: begin
                    fin.w = fin_tag.own_val;
                    fin.x = quo0;
                    fin.y = quo1;
                    fin.z = quo2;
                end
                BR_X: begin
                    fin.w = quo0;
                    fin.x = fin_tag.own_val;
                    fin.y = quo1;
                    fin.z = quo2;
                end
                BR_Y: begin
                    fin.w = quo0;
                    fin.x = quo1;
                    fin.y = fin_tag.own_val;
                    fin.z = quo2;
                end
                BR_Z: begin
                    fin.w = quo0;
                    fin.x = quo1;
                    fin.y = quo2;
                    fin.z = fin_tag.own_val;
                end
                default: begin
                    fin.w = '0;
                    fin.x = '0;
                    fin.y = '0;
                    fin.z = '0;
                end
            endcase
        end
    end

    // Output register with a skid entry behind it.
    assign out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= fin_tag.valid;
        end else begin
            r_skid_valid <= fin_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            r_out <= fin;
        end else begin
            r_skid <= fin;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_quat_w     = r_out.w;
    assign o_quat_x     = r_out.x;
    assign o_quat_y     = r_out.y;
    assign o_quat_z     = r_out.z;
    assign o_degenerate = r_out.deg;

endmodule

>>> rtl/core/rmq_checker.sv
module rmq_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_stall,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic signed [rmq_pkg::DATA_WIDTH-1:0] o_quat_w,
    input logic signed [rmq_pkg::DATA_WIDTH-1:0] o_quat_x,
    input logic signed [rmq_pkg::DATA_WIDTH-1:0] o_quat_y,
    input logic signed [rmq_pkg::DATA_WIDTH-1:0] o_quat_z,
    input logic                                  o_degenerate
);
    import rmq_pkg::*;

    // A degenerate result carries an all-zero quaternion.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_quat_w == '0 && o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0))
        else $error("degenerate result with nonzero components");

    // The input side is held off only after a result was stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // The buffered result drains as soon as the output is taken.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !i_stall) |=> !o_stall)
        else $error("skid entry not drained");

    // A stalled result stays valid, and its w, x and degenerate outputs hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_quat_w) && $stable(o_quat_x) && $stable(o_degenerate)))
        else $error("stalled result changed");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_quat_w     (o_quat_w),
    .o_quat_x     (o_quat_x),
    .o_quat_y     (o_quat_y),
    .o_quat_z     (o_quat_z),
    .o_degenerate (o_degenerate)
);
